// ===== hw/rtl/s2i_pkg.sv =====
// ----------------------------------------------------------------------------
// s2i_pkg
// Types, codes and helper functions shared by the string to integer parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

    localparam int LONG_BITS   = 64;
    localparam int OFFSET_BITS = 16;

    localparam int VALUE_W = 64;
    localparam int EOFF_W  = 16;

    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [VALUE_W-1:0]     t_value;

    // configuration register indexes
    localparam logic [1:0] REG_NUMBER_BASE = 2'd0;
    localparam logic [1:0] REG_RESULT_KIND = 2'd1;

    // number bases
    localparam logic [4:0] BASE_AUTO = 5'd0;
    localparam logic [4:0] BASE_OCT  = 5'd8;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    // result kinds
    localparam logic [1:0] KIND_U64  = 2'd0;
    localparam logic [1:0] KIND_S64  = 2'd1;
    localparam logic [1:0] KIND_ULNG = 2'd2;
    localparam logic [1:0] KIND_SLNG = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_NO_CONV = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_AUTO_ZERO,
        PH_HEX_ZERO,
        PH_DIGITS,
        PH_HALT
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        t_value     acc;
        logic       neg;
        logic [4:0] base;
        t_offset    pos;
        t_offset    stop;
        logic       ovf;
        logic       no_conv;
    } t_parse_state;

    typedef struct packed {
        t_value            value;
        logic [EOFF_W-1:0] end_offset;
        logic [1:0]        status;
    } t_result;

    function automatic t_offset offset_inc(input t_offset p);
        return (p == {OFFSET_BITS{1'b1}}) ? p : p + t_offset'(1);
    endfunction

    function automatic logic [EOFF_W-1:0] offset_to_port(input t_offset p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[EOFF_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/s2i_char_if.sv =====
// ----------------------------------------------------------------------------
// s2i_char_if
// Character stream channel: one string byte per beat.
// ----------------------------------------------------------------------------
interface s2i_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// ===== hw/rtl/s2i_res_if.sv =====
// ----------------------------------------------------------------------------
// s2i_res_if
// Result channel: one parsed integer per beat.
// ----------------------------------------------------------------------------
interface s2i_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [15:0] end_offset;
    logic [1:0]  status;

    modport source (output valid, output value, output end_offset, output status,
                    input ready);
    modport sink   (input valid, input value, input end_offset, input status,
                    output ready);
endinterface

// ===== hw/rtl/s2i_step.sv =====
// ----------------------------------------------------------------------------
// s2i_step
// Next parse state for one non-NUL character: sign, prefix and digit steps.
// ----------------------------------------------------------------------------
module s2i_step (
    input  logic [7:0]            i_character,
    input  logic [4:0]            i_number_base,
    input  s2i_pkg::t_parse_state i_state,
    output s2i_pkg::t_parse_state o_state
);

    logic [7:0]            lower;
    logic                  is_dec;
    logic                  is_alpha;
    logic                  is_x;
    logic [3:0]            dval;
    logic                  dvalid;
    s2i_pkg::t_offset      pos_inc;
    logic                  first;
    logic                  take;
    logic [4:0]            tbase;
    logic [67:0]           prod;
    logic [64:0]           sum;

    assign lower    = i_character | s2i_pkg::CH_CASE;
    assign is_dec   = (i_character >= s2i_pkg::CH_0) && (i_character <= s2i_pkg::CH_9);
    assign is_alpha = (lower >= s2i_pkg::CH_A) && (lower <= s2i_pkg::CH_F);
    assign is_x     = (lower == s2i_pkg::CH_X);
    assign dval     = is_dec ? i_character[3:0] : 4'(lower - s2i_pkg::CH_A + 8'd10);
    assign dvalid   = is_dec || is_alpha;
    assign pos_inc  = s2i_pkg::offset_inc(i_state.pos);

    always_comb begin
        o_state = i_state;
        first   = 1'b0;
        take    = 1'b0;
        tbase   = i_state.base;
        prod    = '0;
        sum     = '0;

        unique case (i_state.phase)
            s2i_pkg::PH_SPACE: begin
                if (i_character == s2i_pkg::CH_SPACE) begin
                    // skip leading blanks
                end else if (i_character == s2i_pkg::CH_PLUS ||
                             i_character == s2i_pkg::CH_MINUS) begin
                    o_state.neg   = (i_character == s2i_pkg::CH_MINUS);
                    o_state.stop  = pos_inc;
                    o_state.phase = s2i_pkg::PH_SIGNED;
                end else begin
                    first = 1'b1;
                end
            end
            s2i_pkg::PH_SIGNED: first = 1'b1;
            s2i_pkg::PH_AUTO_ZERO: begin
                if (is_x) begin
                    o_state.base  = s2i_pkg::BASE_HEX;
                    o_state.stop  = pos_inc;
                    o_state.phase = s2i_pkg::PH_DIGITS;
                end else begin
                    tbase = s2i_pkg::BASE_OCT;
                    take  = 1'b1;
                end
            end
            s2i_pkg::PH_HEX_ZERO: begin
                if (is_x) begin
                    o_state.stop  = pos_inc;
                    o_state.phase = s2i_pkg::PH_DIGITS;
                end else begin
                    take = 1'b1;
                end
            end
            s2i_pkg::PH_DIGITS: take = 1'b1;
            s2i_pkg::PH_HALT: begin
                // ignore everything up to the NUL
            end
            default: o_state.phase = s2i_pkg::PH_HALT;
        endcase

        // first character after blanks and sign: resolve the base
        if (first) begin
            priority if (i_number_base == s2i_pkg::BASE_AUTO) begin
                if (i_character == s2i_pkg::CH_0) begin
                    o_state.stop  = pos_inc;
                    o_state.phase = s2i_pkg::PH_AUTO_ZERO;
                end else begin
                    tbase = s2i_pkg::BASE_DEC;
                    take  = 1'b1;
                end
            end else if (i_number_base == s2i_pkg::BASE_OCT ||
                         i_number_base == s2i_pkg::BASE_HEX) begin
                tbase = i_number_base;
                if (i_character == s2i_pkg::CH_0) begin
                    o_state.stop  = pos_inc;
                    o_state.phase = (i_number_base == s2i_pkg::BASE_HEX) ?
                                    s2i_pkg::PH_HEX_ZERO : s2i_pkg::PH_DIGITS;
                end else if (i_number_base == s2i_pkg::BASE_HEX && is_x) begin
                    o_state.stop  = pos_inc;
                    o_state.phase = s2i_pkg::PH_DIGITS;
                end else begin
                    take = 1'b1;
                end
            end else if (i_number_base == s2i_pkg::BASE_DEC) begin
                tbase = s2i_pkg::BASE_DEC;
                take  = 1'b1;
            end else begin
                o_state.no_conv = 1'b1;
                o_state.phase   = s2i_pkg::PH_HALT;
            end
        end

        o_state.base = (first || take) ? tbase : o_state.base;

        if (take) begin
            unique case (tbase)
                s2i_pkg::BASE_OCT: prod = {1'b0, i_state.acc, 3'b000};
                s2i_pkg::BASE_HEX: prod = {i_state.acc, 4'b0000};
                s2i_pkg::BASE_DEC: prod = {3'b000, i_state.acc, 1'b0} +
                                          {1'b0, i_state.acc, 3'b000};
                default:           prod = '0;
            endcase
            sum = {1'b0, prod[63:0]} + 65'(dval);

            priority if (tbase == s2i_pkg::BASE_AUTO || !dvalid ||
                         {1'b0, dval} >= tbase) begin
                o_state.stop  = i_state.pos;
                o_state.phase = s2i_pkg::PH_HALT;
            end else if (prod[67:64] != 4'd0 || sum[64]) begin
                o_state.ovf   = 1'b1;
                o_state.phase = s2i_pkg::PH_HALT;
            end else begin
                o_state.acc   = sum[63:0];
                o_state.stop  = pos_inc;
                o_state.phase = s2i_pkg::PH_DIGITS;
            end
        end

        o_state.pos = pos_inc;
    end

endmodule

// ===== hw/rtl/s2i_finish.sv =====
// ----------------------------------------------------------------------------
// s2i_finish
// Range check, clamp and sign handling of the accumulated value at the NUL.
// ----------------------------------------------------------------------------
module s2i_finish (
    input  logic [1:0]            i_result_kind,
    input  s2i_pkg::t_parse_state i_state,
    output s2i_pkg::t_result      o_result
);

    localparam s2i_pkg::t_value ALL1  = {s2i_pkg::VALUE_W{1'b1}};
    localparam s2i_pkg::t_value HALF  = ALL1 >> 1;
    localparam s2i_pkg::t_value LMAX  = ALL1 >> (s2i_pkg::VALUE_W - s2i_pkg::LONG_BITS);
    localparam s2i_pkg::t_value LHALF = LMAX >> 1;

    s2i_pkg::t_value v;
    s2i_pkg::t_value mag;
    s2i_pkg::t_value negv;
    s2i_pkg::t_value value;
    logic            no_conv;
    logic            ovf;
    s2i_pkg::t_offset stop;

    assign v       = i_state.acc;
    assign negv    = s2i_pkg::t_value'(i_state.neg);
    assign mag     = i_state.neg ? (~v + s2i_pkg::t_value'(1)) : v;
    assign no_conv = i_state.no_conv || (i_state.phase == s2i_pkg::PH_SPACE) ||
                     (i_state.phase == s2i_pkg::PH_SIGNED);
    assign stop    = (i_state.phase == s2i_pkg::PH_HALT) ? i_state.stop : i_state.pos;

    always_comb begin
        ovf   = i_state.ovf;
        value = '0;
        unique case (i_result_kind)
            s2i_pkg::KIND_U64: begin
                if (i_state.neg && v > HALF + s2i_pkg::t_value'(1)) ovf = 1'b1;
                value = ovf ? ALL1 : mag;
            end
            s2i_pkg::KIND_S64: begin
                if (v > HALF + negv) ovf = 1'b1;
                value = ovf ? (i_state.neg ? ~HALF : HALF) : mag;
            end
            s2i_pkg::KIND_ULNG: begin
                if ((i_state.neg && v > LHALF + s2i_pkg::t_value'(1)) ||
                    (!i_state.neg && v > LMAX)) ovf = 1'b1;
                value = ovf ? LMAX : (mag & LMAX);
            end
            s2i_pkg::KIND_SLNG: begin
                if (v > LHALF + negv) ovf = 1'b1;
                value = ovf ? (i_state.neg ? ~LHALF : LHALF) : mag;
            end
            default: value = '0;
        endcase

        if (no_conv) begin
            o_result.value      = '0;
            o_result.end_offset = '0;
            o_result.status     = s2i_pkg::ST_NO_CONV;
        end else begin
            o_result.value      = value;
            o_result.end_offset = ovf ? '0 : s2i_pkg::offset_to_port(stop);
            o_result.status     = ovf ? s2i_pkg::ST_OVF : s2i_pkg::ST_OK;
        end
    end

endmodule

// ===== hw/rtl/string_to_integer_parser_core.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser_core
// Parses a NUL-terminated ASCII string, one byte per beat, into an integer.
// ----------------------------------------------------------------------------
// A NUL beat's result passes from the input register through the result
//   register to o_res, where a ready sink takes it.
// Throughput: one character per cycle while no NUL stalls, with the digit step
//   (shift-add multiply by the base plus digit add) combinational between input and state.
// A NUL waits in the input register while the previous result is not taken.
// Reset: synchronous, active low; number_base 10, result_kind 0, parser idle.
module string_to_integer_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2i_char_if.sink    i_char,
    s2i_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    logic [4:0]            r_number_base;
    logic [1:0]            r_result_kind;

    logic                  r_in_valid;
    logic [7:0]            r_in_char;

    s2i_pkg::t_phase       r_phase;
    s2i_pkg::t_phase       n_phase;
    s2i_pkg::t_parse_state r_state;
    s2i_pkg::t_parse_state n_state;
    s2i_pkg::t_parse_state cur_state;
    s2i_pkg::t_parse_state step_state;

    logic                  r_out_valid;
    s2i_pkg::t_result      r_result;
    s2i_pkg::t_result      fin_result;

    logic                  is_nul;
    logic                  stall;
    logic                  fire;
    logic                  nul_fire;

    assign is_nul   = (r_in_char == s2i_pkg::CH_NUL);
    assign stall    = r_in_valid && is_nul && r_out_valid && !o_res.ready;
    assign fire     = r_in_valid && !stall;
    assign nul_fire = fire && is_nul;

    assign i_char.ready = !r_in_valid || fire;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= s2i_pkg::BASE_DEC;
            r_result_kind <= s2i_pkg::KIND_U64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == s2i_pkg::REG_NUMBER_BASE) r_number_base <= i_cfg_data;
            if (i_cfg_index == s2i_pkg::REG_RESULT_KIND) r_result_kind <= i_cfg_data[1:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.character;
        end
    end

    always_comb begin
        cur_state       = r_state;
        cur_state.phase = r_phase;
    end

    s2i_step u_step (
        .i_character   (r_in_char),
        .i_number_base (r_number_base),
        .i_state       (cur_state),
        .o_state       (step_state)
    );

    s2i_finish u_finish (
        .i_result_kind (r_result_kind),
        .i_state       (cur_state),
        .o_result      (fin_result)
    );

    // parse state
    always_comb begin
        n_state = cur_state;
        n_phase = r_phase;
        if (fire) begin
            if (is_nul) begin
                // result captured, start over for the next string
                n_state = '0;
                n_phase = s2i_pkg::PH_SPACE;
            end else begin
                n_state = step_state;
                n_phase = step_state.phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s2i_pkg::PH_SPACE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (nul_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nul_fire) begin
            r_result <= fin_result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_result.value;
    assign o_res.end_offset = r_result.end_offset;
    assign o_res.status     = r_result.status;

    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nul_fire |=> (r_phase == s2i_pkg::PH_SPACE) && (r_state.pos == '0))
        else $error("parse state not cleared after NUL beat");

    a_out_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(nul_fire))
        else $error("result raised without a NUL beat");

    a_stop_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stop <= r_state.pos)
        else $error("stop offset ahead of position");

    a_ovf_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.ovf || r_state.no_conv) |-> (r_phase == s2i_pkg::PH_HALT))
        else $error("overflow or no conversion without halt");

endmodule
